[hdl/ncpu_pkg.sv]
package ncpu_pkg;

   localparam int ADDR_W    = 12;
   localparam int NIB_W     = 4;
   localparam int MEM_DEPTH = 4096;
   localparam int STEP_W    = 3;

   typedef enum logic [NIB_W-1:0] {
      OP_LDI   = 4'd0,
      OP_STORE = 4'd1,
      OP_LOAD  = 4'd2,
      OP_ADD   = 4'd3,
      OP_ADD1  = 4'd4,
      OP_ADC   = 4'd5,
      OP_NAND  = 4'd6,
      OP_NOR   = 4'd7,
      OP_SHR   = 4'd8,
      OP_JMP   = 4'd9,
      OP_JC    = 4'd10,
      OP_JNC   = 4'd11,
      OP_JZ    = 4'd12,
      OP_JNZ   = 4'd13,
      OP_JM    = 4'd14,
      OP_JP    = 4'd15
   } opcode_type;

   typedef enum logic {
      ITEM_LOAD    = 1'b0,
      ITEM_EXECUTE = 1'b1
   } item_op_type;

   typedef enum logic [2:0] {
      ADDR_IP0,
      ADDR_IP1,
      ADDR_IP2,
      ADDR_IP3,
      ADDR_OPND_BUS,
      ADDR_OPND_REG
   } addr_sel_type;

   typedef enum logic [2:0] {
      LAT_NONE,
      LAT_OPC,
      LAT_A0,
      LAT_A1,
      LAT_A2
   } latch_sel_type;

   typedef enum logic [1:0] {
      EXEC_NONE,
      EXEC_IMM,
      EXEC_FULL
   } exec_sel_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_JUMP_IF_IMM,
      SEQ_DONE
   } seq_sel_type;

   typedef struct packed {
      addr_sel_type         addr_sel;
      latch_sel_type        latch_sel;
      exec_sel_type         exec_sel;
      seq_sel_type          seq_sel;
      logic [STEP_W-1:0]    target;
   } ucode_type;

   typedef struct packed {
      logic      active;
      logic      done;
      ucode_type word;
   } seq_ctrl_type;

   localparam logic [STEP_W-1:0] STEP_FETCH = 3'd0;
   localparam logic [STEP_W-1:0] STEP_OPC   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_A0    = 3'd2;
   localparam logic [STEP_W-1:0] STEP_A1    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_A2    = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EXEC  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_IMM   = 3'd6;

   localparam ucode_type UCODE_IDLE = '{ADDR_IP0, LAT_NONE, EXEC_NONE, SEQ_DONE, STEP_FETCH};

   // Read data of an issued address shows on the bus in the next step.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         STEP_FETCH: w = '{ADDR_IP0,      LAT_NONE, EXEC_NONE, SEQ_NEXT,        STEP_FETCH};
         STEP_OPC:   w = '{ADDR_IP1,      LAT_OPC,  EXEC_NONE, SEQ_NEXT,        STEP_FETCH};
         STEP_A0:    w = '{ADDR_IP2,      LAT_A0,   EXEC_NONE, SEQ_JUMP_IF_IMM, STEP_IMM};
         STEP_A1:    w = '{ADDR_IP3,      LAT_A1,   EXEC_NONE, SEQ_NEXT,        STEP_FETCH};
         STEP_A2:    w = '{ADDR_OPND_BUS, LAT_A2,   EXEC_NONE, SEQ_NEXT,        STEP_FETCH};
         STEP_EXEC:  w = '{ADDR_OPND_REG, LAT_NONE, EXEC_FULL, SEQ_DONE,        STEP_FETCH};
         STEP_IMM:   w = '{ADDR_IP0,      LAT_NONE, EXEC_IMM,  SEQ_DONE,        STEP_FETCH};
         default:    w = UCODE_IDLE;
      endcase
      return w;
   endfunction

endpackage

[hdl/nibble_cpu_core.sv]
// 4-bit accumulator CPU with a 4096-nibble program memory on one port. After reset the
// core sweeps the memory to zero with busy high; start is ignored until busy drops. A
// load item writes memory at the accept edge and its item appears on rsp_strobe in the
// next cycle; busy stays low. An execute item reads the instruction one nibble per cycle
// through the single memory port: four fetch reads, the operand access and execute; for
// an immediate load, fetch reads only until its data nibble is in, then execute. Busy is
// high for that time and falls in the cycle that shows the item. Each item is on the rsp_
// ports for exactly one cycle; the receiver cannot stall.
module nibble_cpu_core
   import ncpu_pkg::*;
#(
   parameter int PERIPHERAL_BASE = 3072
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_operation,
   input  logic [ADDR_W-1:0] req_load_address,
   input  logic [7:0]        req_load_data,
   output logic              rsp_strobe,
   output logic [ADDR_W-1:0] rsp_program_counter,
   output logic [NIB_W-1:0]  rsp_accumulator_value,
   output logic              rsp_carry_flag,
   output logic [NIB_W-1:0]  rsp_executed_opcode,
   output logic              rsp_store_strobe,
   output logic [ADDR_W-1:0] rsp_store_address,
   output logic [NIB_W-1:0]  rsp_store_value,
   output logic              rsp_peripheral_hit
);

   localparam logic [ADDR_W:0] PERIPH_LIMIT = (ADDR_W+1)'(PERIPHERAL_BASE);

   logic [NIB_W-1:0]  nibble_mem_ff [MEM_DEPTH];
   logic [NIB_W-1:0]  mem_rdata_ff;
   logic              rd_periph_ff;
   logic [ADDR_W:0]   clr_cnt_ff;
   logic              clearing;

   logic [ADDR_W-1:0] ip_ff, ip_in;
   logic [NIB_W-1:0]  acc_ff, acc_in;
   logic              carry_ff, carry_in;
   opcode_type        opc_ff;
   logic [NIB_W-1:0]  a0_ff, a1_ff, a2_ff;

   logic              rsp_strobe_ff;
   logic [ADDR_W-1:0] rsp_pc_ff;
   logic [NIB_W-1:0]  rsp_acc_ff;
   logic              rsp_carry_ff;
   opcode_type        rsp_opc_ff;
   logic              rsp_st_ff;
   logic [ADDR_W-1:0] rsp_st_addr_ff;
   logic [NIB_W-1:0]  rsp_st_val_ff;
   logic              rsp_phit_ff;

   seq_ctrl_type      ctrl;
   logic              accept, load_accept, exec_accept;
   logic [NIB_W-1:0]  bus;
   logic [ADDR_W-1:0] opnd;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic [NIB_W-1:0]  mem_wdata;
   logic              store_hit, store_periph;
   logic              cin, take;
   logic [NIB_W:0]    sum;

   assign clearing    = !clr_cnt_ff[ADDR_W];
   assign busy        = clearing || ctrl.active;
   assign accept      = start && !busy;
   assign load_accept = accept && (req_operation == ITEM_LOAD);
   assign exec_accept = accept && (req_operation == ITEM_EXECUTE);

   ncpu_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .launch (exec_accept),
      .imm_op (opc_ff == OP_LDI),
      .ctrl   (ctrl)
   );

   // Peripheral range reads as all ones.
   assign bus  = rd_periph_ff ? {NIB_W{1'b1}} : mem_rdata_ff;
   assign opnd = {a0_ff, a1_ff, a2_ff};

   assign store_hit    = (ctrl.word.exec_sel == EXEC_FULL) && (opc_ff == OP_STORE);
   assign store_periph = ({1'b0, opnd} >= PERIPH_LIMIT);

   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = acc_ff;
      if (clearing) begin
         mem_addr  = clr_cnt_ff[ADDR_W-1:0];
         mem_we    = 1'b1;
         mem_wdata = '0;
      end else if (load_accept) begin
         mem_addr  = req_load_address;
         mem_we    = 1'b1;
         mem_wdata = req_load_data[NIB_W-1:0];
      end else begin
         unique case (ctrl.word.addr_sel)
            ADDR_IP0:      mem_addr = ip_ff;
            ADDR_IP1:      mem_addr = ip_ff + 12'd1;
            ADDR_IP2:      mem_addr = ip_ff + 12'd2;
            ADDR_IP3:      mem_addr = ip_ff + 12'd3;
            ADDR_OPND_BUS: mem_addr = {a0_ff, a1_ff, bus};
            ADDR_OPND_REG: mem_addr = opnd;
            default:       mem_addr = ip_ff;
         endcase
         mem_we = store_hit && !store_periph;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         nibble_mem_ff[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= nibble_mem_ff[mem_addr];
      rd_periph_ff <= ({1'b0, mem_addr} >= PERIPH_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (clearing) begin
         clr_cnt_ff <= clr_cnt_ff + (ADDR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.active) begin
         unique case (ctrl.word.latch_sel)
            LAT_OPC:  opc_ff <= opcode_type'(bus);
            LAT_A0:   a0_ff  <= bus;
            LAT_A1:   a1_ff  <= bus;
            LAT_A2:   a2_ff  <= bus;
            default: ;
         endcase
      end
   end

   assign cin = (opc_ff == OP_ADD1) || ((opc_ff == OP_ADC) && carry_ff);
   assign sum = {1'b0, acc_ff} + {1'b0, bus} + {{NIB_W{1'b0}}, cin};

   always_comb begin
      acc_in   = acc_ff;
      carry_in = carry_ff;
      ip_in    = ip_ff;
      take     = 1'b0;
      case (ctrl.word.exec_sel)
         EXEC_IMM: begin
            acc_in   = a0_ff;
            carry_in = 1'b0;
            ip_in    = ip_ff + 12'd2;
         end
         EXEC_FULL: begin
            ip_in = ip_ff + 12'd4;
            unique case (opc_ff)
               OP_LOAD: begin
                  acc_in   = bus;
                  carry_in = 1'b0;
               end
               OP_ADD, OP_ADD1, OP_ADC: begin
                  acc_in   = sum[NIB_W-1:0];
                  carry_in = sum[NIB_W];
               end
               OP_NAND: acc_in = ~(acc_ff & bus);
               OP_NOR:  acc_in = ~(acc_ff | bus);
               OP_SHR:  acc_in = acc_ff >> bus;
               OP_JMP:  take   = 1'b1;
               OP_JC:   take   = carry_ff;
               OP_JNC:  take   = !carry_ff;
               OP_JZ:   take   = (acc_ff == '0);
               OP_JNZ:  take   = (acc_ff != '0);
               OP_JM:   take   = acc_ff[NIB_W-1];
               OP_JP:   take   = !acc_ff[NIB_W-1];
               default: ;
            endcase
            if (take) begin
               ip_in = opnd;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff    <= '0;
         acc_ff   <= '0;
         carry_ff <= 1'b0;
      end else if (ctrl.done) begin
         ip_ff    <= ip_in;
         acc_ff   <= acc_in;
         carry_ff <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= load_accept || ctrl.done;
      end
   end

   always_ff @(posedge clock) begin
      if (load_accept) begin
         rsp_pc_ff      <= ip_ff;
         rsp_acc_ff     <= acc_ff;
         rsp_carry_ff   <= carry_ff;
         rsp_opc_ff     <= OP_LDI;
         rsp_st_ff      <= 1'b0;
         rsp_st_addr_ff <= '0;
         rsp_st_val_ff  <= '0;
         rsp_phit_ff    <= 1'b0;
      end else if (ctrl.done) begin
         rsp_pc_ff      <= ip_in;
         rsp_acc_ff     <= acc_in;
         rsp_carry_ff   <= carry_in;
         rsp_opc_ff     <= (ctrl.word.exec_sel == EXEC_IMM) ? OP_LDI : opc_ff;
         rsp_st_ff      <= store_hit;
         rsp_st_addr_ff <= store_hit ? opnd : '0;
         rsp_st_val_ff  <= store_hit ? acc_ff : '0;
         rsp_phit_ff    <= store_hit && store_periph;
      end
   end

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_program_counter   = rsp_pc_ff;
   assign rsp_accumulator_value = rsp_acc_ff;
   assign rsp_carry_flag        = rsp_carry_ff;
   assign rsp_executed_opcode   = rsp_opc_ff;
   assign rsp_store_strobe      = rsp_st_ff;
   assign rsp_store_address     = rsp_st_addr_ff;
   assign rsp_store_value       = rsp_st_val_ff;
   assign rsp_peripheral_hit    = rsp_phit_ff;

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing && $past(clearing) |-> !rsp_strobe)
      else $error("item delivered during memory clear");

   a_exec_goes_busy: assert property (@(posedge clock) disable iff (reset)
      exec_accept |=> busy && !rsp_strobe)
      else $error("execute item did not hold busy");

   a_store_opcode: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_store_strobe |-> rsp_executed_opcode == OP_STORE)
      else $error("store reported for non-store opcode");

   a_phit_needs_store: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_peripheral_hit |-> rsp_store_strobe)
      else $error("peripheral hit without store");

   a_done_follows_run: assert property (@(posedge clock) disable iff (reset)
      ctrl.done |=> !ctrl.active && rsp_strobe)
      else $error("sequencer did not stop after execute");

endmodule

[hdl/ncpu_seq.sv]
module ncpu_seq
   import ncpu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         launch,
   input  logic         imm_op,
   output seq_ctrl_type ctrl
);

   logic [STEP_W-1:0] upc_ff, upc_in;
   logic              run_ff, run_in;
   ucode_type         word;

   assign word = ucode_rom(upc_ff);

   always_comb begin
      upc_in = upc_ff;
      run_in = run_ff;
      if (launch) begin
         upc_in = STEP_FETCH;
         run_in = 1'b1;
      end else if (run_ff) begin
         unique case (word.seq_sel)
            SEQ_NEXT:        upc_in = upc_ff + 3'd1;
            SEQ_JUMP_IF_IMM: upc_in = imm_op ? word.target : upc_ff + 3'd1;
            SEQ_DONE: begin
               upc_in = STEP_FETCH;
               run_in = 1'b0;
            end
            default:         upc_in = STEP_FETCH;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_FETCH;
         run_ff <= 1'b0;
      end else begin
         upc_ff <= upc_in;
         run_ff <= run_in;
      end
   end

   always_comb begin
      ctrl.active = run_ff;
      ctrl.done   = run_ff && (word.seq_sel == SEQ_DONE);
      ctrl.word   = run_ff ? word : UCODE_IDLE;
   end

endmodule
